// ===== hw/rtl/weight_settling_detector_assert.svh =====
// ----------------------------------------------------------------------------
// weight settling detector assertion macros
// concurrent property wrappers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef WEIGHT_SETTLING_DETECTOR_ASSERT_SVH
`define WEIGHT_SETTLING_DETECTOR_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants of the weight settling detector
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int OUT_W    = 20;
  localparam int THR_W    = 16;
  localparam int LIMIT_W  = 6;
  localparam int STREAK_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OUT_W-1:0]    OUT_MAX    = '1;
  localparam logic [STREAK_W-1:0] STEADY_MAX = '1;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_MEASURE  = 2'd1,
    PH_FALLBACK = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    METHOD_LOCKED   = 2'd0,
    METHOD_FALLBACK = 2'd1,
    METHOD_NONE     = 2'd2
  } method_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_STREAK    = 2'd2
  } cfg_reg_t;

  localparam logic [THR_W-1:0]    THR_RST    = 16'd100;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 6'd15;
  localparam logic [STREAK_W-1:0] STREAK_RST = 3'd2;

endpackage

// ===== hw/rtl/wsd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd channel interfaces
// sample/command input channel and weight result channel
// ----------------------------------------------------------------------------
interface wsd_in_if #(
  parameter int WEIGHT_BITS = 21
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [WEIGHT_BITS-1:0] sample_grams;

  modport source (output valid, command, sample_grams, input ready);
  modport sink   (input valid, command, sample_grams, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] weight_grams;
  logic        no_weight;
  logic [1:0]  method;

  modport source (output valid, weight_grams, no_weight, method, input ready);
  modport sink   (input valid, weight_grams, no_weight, method, output ready);
endinterface

// ===== hw/rtl/weight_settling_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_settling_detector
// finds a settled load-cell weight in a stream of averaged gram samples
// ----------------------------------------------------------------------------
// port     | dir | payload                                 | handshake
// in_ch    | in  | command, sample_grams                   | valid/ready
// out_ch   | out | weight_grams, no_weight, method         | valid/ready
// cfg_*    | in  | cfg_index, cfg_wdata                    | cfg_we only
//
// one transaction per cycle while in_ch.ready is high; state updates on accept
// a result appears in the cycle after the transaction that causes it
// the result register frees in the same cycle it is taken, so input keeps flowing
// in_ch.ready drops only while a result waits and out_ch.ready is low
// synchronous active-low reset, measurement idle, registers at their defaults
// ----------------------------------------------------------------------------
`include "weight_settling_detector_assert.svh"

module weight_settling_detector
  import wsd_pkg::*;
#(
  parameter int WEIGHT_BITS  = 21,
  parameter int ATTEMPT_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wsd_in_if.sink                in_ch,
  wsd_out_if.source             out_ch
);

  localparam int MAG_W = WEIGHT_BITS - 1;
  localparam int EXT_W = (MAG_W > OUT_W) ? MAG_W : OUT_W;
  localparam int CMP_W = (ATTEMPT_BITS > LIMIT_W) ? ATTEMPT_BITS : LIMIT_W;
  localparam logic [ATTEMPT_BITS-1:0] CNT_MAX = '1;

  logic [THR_W-1:0]        thr_r;
  logic [LIMIT_W-1:0]      limit_r;
  logic [STREAK_W-1:0]     streak_r;

  phase_t                  phase_r, phase_nxt;
  logic [OUT_W-1:0]        prev_r, prev_nxt;
  logic [STREAK_W-1:0]     steady_r, steady_nxt;
  logic [ATTEMPT_BITS-1:0] attempt_r, attempt_nxt;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_weight_r;
  logic                    out_no_weight_r;
  method_t                 out_method_r;

  logic                    accept;
  logic [EXT_W-1:0]        mag_ext;
  logic [OUT_W-1:0]        cur;
  logic [OUT_W-1:0]        delta;
  logic [OUT_W:0]          pair_sum;
  logic [STREAK_W-1:0]     steady_inc;
  logic [ATTEMPT_BITS-1:0] attempt_inc;
  logic                    emit;
  logic [OUT_W-1:0]        res_weight;
  method_t                 res_method;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // clamp negative to zero, saturate above 20 bits
  always_comb begin
    mag_ext = EXT_W'(unsigned'(in_ch.sample_grams[MAG_W-1:0]));
    if (in_ch.sample_grams[WEIGHT_BITS-1]) begin
      cur = '0;
    end else if (mag_ext > EXT_W'(OUT_MAX)) begin
      cur = OUT_MAX;
    end else begin
      cur = mag_ext[OUT_W-1:0];
    end
  end

  assign delta       = (cur >= prev_r) ? (cur - prev_r) : (prev_r - cur);
  assign pair_sum    = {1'b0, cur} + {1'b0, prev_r};
  assign steady_inc  = (steady_r == STEADY_MAX) ? steady_r : steady_r + 1'b1;
  assign attempt_inc = (attempt_r == CNT_MAX) ? attempt_r : attempt_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    steady_nxt  = steady_r;
    attempt_nxt = attempt_r;
    emit        = 1'b0;
    res_weight  = '0;
    res_method  = METHOD_NONE;
    if (accept) begin
      if (in_ch.command == CMD_START) begin
        phase_nxt   = PH_MEASURE;
        prev_nxt    = '0;
        steady_nxt  = '0;
        attempt_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_FALLBACK: begin
            emit       = 1'b1;
            res_weight = cur;
            res_method = METHOD_FALLBACK;
            phase_nxt  = PH_IDLE;
          end
          PH_MEASURE: begin
            if (attempt_r != '0) begin
              if (delta <= OUT_W'(thr_r)) begin
                steady_nxt = steady_inc;
                if (steady_inc >= streak_r) begin
                  emit       = 1'b1;
                  res_weight = pair_sum[OUT_W:1];
                  res_method = METHOD_LOCKED;
                  phase_nxt  = PH_IDLE;
                end
              end else begin
                steady_nxt = '0;
              end
            end
            if (!emit) begin
              prev_nxt    = cur;
              attempt_nxt = attempt_inc;
              if (CMP_W'(attempt_inc) >= CMP_W'(limit_r) || attempt_inc == CNT_MAX) begin
                if (cur != '0) begin
                  phase_nxt = PH_FALLBACK;
                end else begin
                  emit       = 1'b1;
                  res_weight = '0;
                  res_method = METHOD_NONE;
                  phase_nxt  = PH_IDLE;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      limit_r  <= LIMIT_RST;
      streak_r <= STREAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        REG_LIMIT:     limit_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_STREAK:    streak_r <= cfg_wdata[STREAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      prev_r    <= '0;
      steady_r  <= '0;
      attempt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      prev_r    <= prev_nxt;
      steady_r  <= steady_nxt;
      attempt_r <= attempt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_weight_r    <= res_weight;
      out_no_weight_r <= (res_weight == '0);
      out_method_r    <= res_method;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.weight_grams = out_weight_r;
  assign out_ch.no_weight    = out_no_weight_r;
  assign out_ch.method       = out_method_r;

  `WSD_ASSERT_IMPL(a_no_weight_flag, clk, rst_n, out_valid_r,
                   out_no_weight_r == (out_weight_r == '0))
  `WSD_ASSERT_IMPL(a_none_is_zero, clk, rst_n, out_valid_r && out_method_r == METHOD_NONE,
                   out_weight_r == '0)
  `WSD_ASSERT_NEXT(a_emit_goes_idle, clk, rst_n, emit, phase_r == PH_IDLE && out_valid_r)
  `WSD_ASSERT_IMPL(a_fallback_has_sample, clk, rst_n, phase_r == PH_FALLBACK,
                   prev_r != '0)

endmodule
